[rtl/core/sbb_pkg.sv]
package sbb_pkg;

    localparam int DIV_STEPS = 23;

    localparam logic [22:0] CLK_P3 = 23'd6000000;
    localparam logic [22:0] CLK_P2 = 23'd750000;
    localparam logic [22:0] CLK_P1 = 23'd93750;
    localparam logic [22:0] CLK_P0 = 23'd11719;

    localparam logic [23:0] THR_P3 = 24'(6000000 / 255);
    localparam logic [23:0] THR_P2 = 24'(750000 / 255);
    localparam logic [23:0] THR_P1 = 24'(93750 / 255);

    localparam logic [23:0] RATE_SP_A = 24'd921600;
    localparam logic [23:0] RATE_SP_B = 24'd307200;
    localparam logic [7:0]  FACT_SP_A = 8'hF3;
    localparam logic [7:0]  FACT_SP_B = 8'hD9;
    localparam logic [2:0]  PRESC_SP  = 3'd7;

    localparam logic [7:0]  VER_SHORT = 8'h27;
    localparam logic [7:0]  VER_LINE  = 8'h30;

    localparam logic [7:0]  REQ_RESET = 8'hA1;
    localparam logic [7:0]  REQ_WRITE = 8'h9A;
    localparam logic [7:0]  REQ_HAND  = 8'hA4;
    localparam logic [15:0] VAL_BAUD  = 16'h1312;
    localparam logic [15:0] VAL_LINE  = 16'h2518;
    localparam logic [15:0] IDX_LINE  = 16'h00C3;
    localparam logic [15:0] VAL_HAND  = 16'hFFFF;

    typedef struct packed {
        logic [23:0] line_rate;
        logic [7:0]  chip_rev;
    } t_in_item;

    typedef struct packed {
        logic        ok;
        logic [7:0]  request_code;
        logic [15:0] request_value;
        logic [15:0] request_index;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [23:0] rem;
        logic [22:0] num;
        logic [23:0] den;
        logic [22:0] quo;
    } t_div;

    typedef t_div [1:0] t_lanes;

    typedef struct packed {
        logic [23:0] rate;
        logic [7:0]  ver;
        logic [1:0]  presc;
        logic        fail;
        logic        sp_a;
        logic        sp_b;
        logic [7:0]  q8;
    } t_ctx;

    typedef struct packed {
        logic        fail;
        logic        line;
        logic [15:0] word;
    } t_plan;

    function automatic logic [22:0] clk_of(input logic [1:0] presc);
        logic [22:0] c;
        unique case (presc)
            2'd3:    c = CLK_P3;
            2'd2:    c = CLK_P2;
            2'd1:    c = CLK_P1;
            default: c = CLK_P0;
        endcase
        return c;
    endfunction

endpackage

[rtl/core/sbb_cell.sv]
module sbb_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  sbb_pkg::t_lanes i_lanes,
    input  sbb_pkg::t_ctx  i_ctx,
    output logic           o_valid,
    output sbb_pkg::t_lanes o_lanes,
    output sbb_pkg::t_ctx  o_ctx
);
    import sbb_pkg::*;

    logic   r_valid;
    t_lanes r_lanes;
    t_ctx   r_ctx;
    t_lanes n_lanes;
    logic [24:0] w_part [2];
    logic        w_ge [2];

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            w_part[k] = {i_lanes[k].rem, i_lanes[k].num[22]};
            w_ge[k] = w_part[k] >= {1'b0, i_lanes[k].den};
            n_lanes[k].den = i_lanes[k].den;
            n_lanes[k].num = {i_lanes[k].num[21:0], 1'b0};
            n_lanes[k].quo = {i_lanes[k].quo[21:0], w_ge[k]};
            n_lanes[k].rem = w_ge[k] ? 24'(w_part[k] - {1'b0, i_lanes[k].den})
                                     : w_part[k][23:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lanes <= n_lanes;
            r_ctx   <= i_ctx;
        end
    end

    assign o_valid = r_valid;
    assign o_lanes = r_lanes;
    assign o_ctx   = r_ctx;

endmodule

[rtl/core/sbb_emit.sv]
module sbb_emit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  sbb_pkg::t_plan    i_plan,
    output logic              o_take,
    output logic              o_valid,
    output sbb_pkg::t_out_item o_item,
    input  logic              i_stall
);
    import sbb_pkg::*;

    typedef enum logic [1:0] {ST_RESET, ST_BAUD, ST_LINE, ST_HAND} t_step;

    t_step r_step;
    logic  r_busy;
    t_plan r_plan;
    logic  w_last;

    always_comb begin
        w_last = r_plan.fail || (r_step == ST_HAND);
        o_take = i_valid && (!r_busy || (!i_stall && w_last));
        o_item = '0;
        o_item.last = w_last;
        if (!r_plan.fail) begin
            o_item.ok = 1'b1;
            unique case (r_step)
                ST_RESET: begin
                    o_item.request_code = REQ_RESET;
                end
                ST_BAUD: begin
                    o_item.request_code  = REQ_WRITE;
                    o_item.request_value = VAL_BAUD;
                    o_item.request_index = r_plan.word;
                end
                ST_LINE: begin
                    o_item.request_code  = REQ_WRITE;
                    o_item.request_value = VAL_LINE;
                    o_item.request_index = IDX_LINE;
                end
                ST_HAND: begin
                    o_item.request_code  = REQ_HAND;
                    o_item.request_value = VAL_HAND;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= ST_RESET;
        end else if (o_take) begin
            r_busy <= 1'b1;
            r_step <= ST_RESET;
            r_plan <= i_plan;
        end else if (r_busy && !i_stall) begin
            if (w_last) begin
                r_busy <= 1'b0;
            end else begin
                unique case (r_step)
                    ST_RESET: r_step <= ST_BAUD;
                    ST_BAUD:  r_step <= r_plan.line ? ST_LINE : ST_HAND;
                    ST_LINE:  r_step <= ST_HAND;
                    ST_HAND:  r_step <= ST_HAND;
                endcase
            end
        end
    end

    assign o_valid = r_busy;

endmodule

[rtl/core/serial_bridge_baud_init_plan.sv]
// Takes a baud rate and a chip revision and emits the bridge setup requests in order: reset,
// baud, line control (revisions 0x30 and above) and handshake, or a single failure item when
// the rate cannot be encoded. The baud factor comes from two chains of 23 restoring divider
// cells, the first finding the quotient of the prescaler clock by the rate and the second
// dividing the clock by that quotient and by the quotient plus one. An item passes the prep
// register, first chain, mid register, second chain and fin register. A new item can be accepted
// every cycle while the pipeline is free; the sustained rate is set by the output serializer,
// one result per cycle unless stalled: three or four per item, one for a failing item.
module serial_bridge_baud_init_plan (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  sbb_pkg::t_in_item  i_item,
    output logic               o_stall,
    output logic               o_valid,
    output sbb_pkg::t_out_item o_item,
    input  logic               i_stall
);
    import sbb_pkg::*;

    logic   w_en;
    logic   w_take;

    logic   r_prep_valid;
    t_lanes r_prep_lanes;
    t_ctx   r_prep_ctx;
    t_lanes n_prep_lanes;
    t_ctx   n_prep_ctx;

    logic   a_valid [DIV_STEPS+1];
    t_lanes a_lanes [DIV_STEPS+1];
    t_ctx   a_ctx   [DIV_STEPS+1];

    logic   r_mid_valid;
    t_lanes r_mid_lanes;
    t_ctx   r_mid_ctx;
    t_lanes n_mid_lanes;
    t_ctx   n_mid_ctx;

    logic   b_valid [DIV_STEPS+1];
    t_lanes b_lanes [DIV_STEPS+1];
    t_ctx   b_ctx   [DIV_STEPS+1];

    logic   r_fin_valid;
    t_plan  r_fin_plan;
    t_plan  n_fin_plan;

    logic [22:0] w_q;
    logic [23:0] w_above;
    logic [23:0] w_below;
    logic [7:0]  w_qf;
    logic [7:0]  w_factor;
    logic [2:0]  w_presc;

    assign w_en    = !r_fin_valid || w_take;
    assign o_stall = !w_en;

    always_comb begin
        n_prep_ctx      = '0;
        n_prep_ctx.rate = i_item.line_rate;
        n_prep_ctx.ver  = i_item.chip_rev;
        n_prep_ctx.fail = (i_item.line_rate == '0);
        n_prep_ctx.sp_a = (i_item.line_rate == RATE_SP_A);
        n_prep_ctx.sp_b = (i_item.line_rate == RATE_SP_B);
        priority if (i_item.line_rate > THR_P3) begin
            n_prep_ctx.presc = 2'd3;
        end else if (i_item.line_rate > THR_P2) begin
            n_prep_ctx.presc = 2'd2;
        end else if (i_item.line_rate > THR_P1) begin
            n_prep_ctx.presc = 2'd1;
        end else begin
            n_prep_ctx.presc = 2'd0;
        end
        n_prep_lanes        = '0;
        n_prep_lanes[0].num = clk_of(n_prep_ctx.presc);
        n_prep_lanes[0].den = i_item.line_rate;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prep_valid <= 1'b0;
            r_mid_valid  <= 1'b0;
            r_fin_valid  <= 1'b0;
        end else if (w_en) begin
            r_prep_valid <= i_valid;
            r_mid_valid  <= a_valid[DIV_STEPS];
            r_fin_valid  <= b_valid[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_prep_lanes <= n_prep_lanes;
            r_prep_ctx   <= n_prep_ctx;
            r_mid_lanes  <= n_mid_lanes;
            r_mid_ctx    <= n_mid_ctx;
            r_fin_plan   <= n_fin_plan;
        end
    end

    assign a_valid[0] = r_prep_valid;
    assign a_lanes[0] = r_prep_lanes;
    assign a_ctx[0]   = r_prep_ctx;

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div_a
        sbb_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (a_valid[g]),
            .i_lanes (a_lanes[g]),
            .i_ctx   (a_ctx[g]),
            .o_valid (a_valid[g+1]),
            .o_lanes (a_lanes[g+1]),
            .o_ctx   (a_ctx[g+1])
        );
    end

    always_comb begin
        w_q            = a_lanes[DIV_STEPS][0].quo;
        n_mid_ctx      = a_ctx[DIV_STEPS];
        n_mid_ctx.q8   = w_q[7:0];
        n_mid_ctx.fail = a_ctx[DIV_STEPS].fail || (w_q == 23'd0) || (w_q == 23'd255);
        n_mid_lanes        = '0;
        n_mid_lanes[0].num = clk_of(a_ctx[DIV_STEPS].presc);
        n_mid_lanes[1].num = clk_of(a_ctx[DIV_STEPS].presc);
        n_mid_lanes[0].den = {1'b0, w_q};
        n_mid_lanes[1].den = 24'({1'b0, w_q} + 24'd1);
    end

    assign b_valid[0] = r_mid_valid;
    assign b_lanes[0] = r_mid_lanes;
    assign b_ctx[0]   = r_mid_ctx;

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div_b
        sbb_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (b_valid[g]),
            .i_lanes (b_lanes[g]),
            .i_ctx   (b_ctx[g]),
            .o_valid (b_valid[g+1]),
            .o_lanes (b_lanes[g+1]),
            .o_ctx   (b_ctx[g+1])
        );
    end

    always_comb begin
        w_above  = 24'({1'b0, b_lanes[DIV_STEPS][0].quo} - b_ctx[DIV_STEPS].rate);
        w_below  = 24'(b_ctx[DIV_STEPS].rate - {1'b0, b_lanes[DIV_STEPS][1].quo});
        w_qf     = 8'(b_ctx[DIV_STEPS].q8 + {7'd0, (w_above > w_below)});
        w_factor = 8'(8'd0 - w_qf);
        w_presc  = {1'b0, b_ctx[DIV_STEPS].presc};
        if (b_ctx[DIV_STEPS].sp_a) begin
            w_factor = FACT_SP_A;
            w_presc  = PRESC_SP;
        end else if (b_ctx[DIV_STEPS].sp_b) begin
            w_factor = FACT_SP_B;
            w_presc  = PRESC_SP;
        end
        n_fin_plan.fail = b_ctx[DIV_STEPS].fail && !b_ctx[DIV_STEPS].sp_a
                          && !b_ctx[DIV_STEPS].sp_b;
        n_fin_plan.line = (b_ctx[DIV_STEPS].ver >= VER_LINE);
        n_fin_plan.word = {w_factor, (b_ctx[DIV_STEPS].ver > VER_SHORT), 4'd0, w_presc};
    end

    sbb_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_fin_valid),
        .i_plan  (r_fin_plan),
        .o_take  (w_take),
        .o_valid (o_valid),
        .o_item  (o_item),
        .i_stall (i_stall)
    );

endmodule

[tb/tb_serial_bridge_baud_init_plan.sv]
`timescale 1ns / 100ps

module tb_serial_bridge_baud_init_plan;
    import sbb_pkg::*;

    localparam int RANDOM_ITEMS = 110;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_AT = 60;
    localparam int HOLD_CYCLES = 400;
    localparam int PAUSE_AT = 100;
    localparam int DRAIN_CYCLES = 80;

    localparam logic [23:0] COMMON_RATES [16] = '{
        24'd300, 24'd1200, 24'd2400, 24'd4800, 24'd9600, 24'd19200, 24'd38400,
        24'd57600, 24'd115200, 24'd230400, 24'd460800, 24'd921600, 24'd307200,
        24'd1000000, 24'd2000000, 24'd3000000
    };
    localparam logic [23:0] EDGE_RATES [10] = '{
        24'd367, 24'd368, 24'd2941, 24'd2942, 24'd23529, 24'd23530,
        24'd6000000, 24'd6000001, 24'd1, 24'd2
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       drv_valid = 1'b0;
    t_in_item   drv_item = '0;
    logic       rx_stall = 1'b0;
    logic       o_stall;
    logic       o_valid;
    t_out_item  o_item;

    t_in_item   pending_q[$];
    t_out_item  planned_q[$];

    int         cycle_cnt = 0;
    int         accepted_cnt = 0;
    int         planned_cnt = 0;
    int         received_cnt = 0;
    int         error_cnt = 0;
    int         gap_left = 0;
    int         stall_left = 0;
    int         hold_left = 0;
    bit         hold_done = 1'b0;
    bit         pause_done = 1'b0;

    serial_bridge_baud_init_plan dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (drv_valid),
        .i_item  (drv_item),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_item  (o_item),
        .i_stall (rx_stall)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_out_item make_req(input logic ok, input logic [7:0] code,
                                           input logic [15:0] value,
                                           input logic [15:0] index, input logic last);
        t_out_item r;
        r.ok = ok;
        r.request_code = code;
        r.request_value = value;
        r.request_index = index;
        r.last = last;
        return r;
    endfunction

    function automatic int plan_requests(input t_in_item it);
        logic [31:0] rate;
        logic [31:0] clk_hz;
        logic [31:0] q;
        logic [31:0] above;
        logic [31:0] below;
        logic [7:0]  factor;
        logic [2:0]  presc;
        logic [15:0] word;
        logic        fail;
        int          cnt;
        rate = {8'd0, it.line_rate};
        fail = 1'b0;
        factor = '0;
        presc = '0;
        cnt = 0;
        if (rate == 0) begin
            fail = 1'b1;
        end else if (it.line_rate == RATE_SP_A) begin
            factor = FACT_SP_A;
            presc = PRESC_SP;
        end else if (it.line_rate == RATE_SP_B) begin
            factor = FACT_SP_B;
            presc = PRESC_SP;
        end else begin
            if (it.line_rate > THR_P3) begin
                presc = 3'd3;
                clk_hz = 32'(CLK_P3);
            end else if (it.line_rate > THR_P2) begin
                presc = 3'd2;
                clk_hz = 32'(CLK_P2);
            end else if (it.line_rate > THR_P1) begin
                presc = 3'd1;
                clk_hz = 32'(CLK_P1);
            end else begin
                presc = 3'd0;
                clk_hz = 32'(CLK_P0);
            end
            q = clk_hz / rate;
            if (q == 0 || q == 32'd255) begin
                fail = 1'b1;
            end else begin
                above = clk_hz / q - rate;
                below = rate - clk_hz / (q + 1);
                if (above > below) begin
                    q = q + 1;
                end
                factor = 8'(32'd256 - q);
            end
        end
        if (fail) begin
            planned_q.push_back(make_req(1'b0, 8'd0, 16'd0, 16'd0, 1'b1));
            cnt = 1;
        end else begin
            word = {factor, 5'd0, presc};
            if (it.chip_rev > VER_SHORT) begin
                word[7] = 1'b1;
            end
            planned_q.push_back(make_req(1'b1, REQ_RESET, 16'd0, 16'd0, 1'b0));
            planned_q.push_back(make_req(1'b1, REQ_WRITE, VAL_BAUD, word, 1'b0));
            cnt = 3;
            if (it.chip_rev >= VER_LINE) begin
                planned_q.push_back(make_req(1'b1, REQ_WRITE, VAL_LINE, IDX_LINE, 1'b0));
                cnt = 4;
            end
            planned_q.push_back(make_req(1'b1, REQ_HAND, VAL_HAND, 16'd0, 1'b1));
        end
        return cnt;
    endfunction

    function automatic int pick_idle(input int cycle);
        int r;
        r = $urandom_range(0, 99);
        if (((cycle >> 10) % 4) == 0 || r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic t_in_item random_item();
        t_in_item it;
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: it.line_rate = 24'($urandom_range(1, 367));
            1: it.line_rate = 24'($urandom_range(368, 2941));
            2: it.line_rate = 24'($urandom_range(2942, 23529));
            3, 4: it.line_rate = 24'($urandom_range(23530, 6000000));
            5, 6: it.line_rate = COMMON_RATES[$urandom_range(0, 15)];
            7: it.line_rate = EDGE_RATES[$urandom_range(0, 9)];
            8: it.line_rate = 24'($urandom);
            default: it.line_rate = ($urandom_range(0, 3) == 0) ? 24'd0
                                                                 : 24'($urandom_range(6000001, 16777215));
        endcase
        if ($urandom_range(0, 1) == 0) begin
            it.chip_rev = 8'($urandom_range(0, 255));
        end else begin
            it.chip_rev = 8'($urandom_range(8'h20, 8'h38));
        end
        return it;
    endfunction

    function automatic t_in_item build_item(input logic [23:0] rate, input logic [7:0] ver);
        t_in_item it;
        it.line_rate = rate;
        it.chip_rev = ver;
        return it;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: mismatch in %s, expected %h, actual %h", $time, name, want, got);
            error_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (drv_valid && !o_stall) begin
                accepted_cnt <= accepted_cnt + 1;
                planned_cnt <= planned_cnt + plan_requests(drv_item);
                gap_left = pick_idle(cycle_cnt);
            end
            if (!drv_valid || !o_stall) begin
                if (!pause_done && accepted_cnt >= PAUSE_AT) begin
                    if (received_cnt == planned_cnt && !(drv_valid && !o_stall)) begin
                        pause_done = 1'b1;
                    end
                    drv_valid <= 1'b0;
                end else if (gap_left > 0) begin
                    gap_left--;
                    drv_valid <= 1'b0;
                end else if (pending_q.size() > 0) begin
                    drv_item <= pending_q.pop_front();
                    drv_valid <= 1'b1;
                end else begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (o_valid && !rx_stall) begin
                received_cnt <= received_cnt + 1;
                if (planned_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, o_item);
                    error_cnt++;
                end else begin
                    want = planned_q.pop_front();
                    check_field("ok", 16'(want.ok), 16'(o_item.ok));
                    check_field("request_code", 16'(want.request_code),
                                16'(o_item.request_code));
                    check_field("request_value", want.request_value, o_item.request_value);
                    check_field("request_index", want.request_index, o_item.request_index);
                    check_field("last", 16'(want.last), 16'(o_item.last));
                end
            end
            if (!hold_done && accepted_cnt >= HOLD_AT) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                rx_stall <= 1'b1;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                rx_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                rx_stall <= 1'b1;
            end else begin
                stall_left <= pick_idle(cycle_cnt + 512);
                rx_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        pending_q.push_back(build_item(24'd0, 8'h30));
        pending_q.push_back(build_item(24'd921600, 8'h27));
        pending_q.push_back(build_item(24'd921600, 8'h30));
        pending_q.push_back(build_item(24'd307200, 8'h28));
        pending_q.push_back(build_item(24'd307200, 8'hFF));
        pending_q.push_back(build_item(24'd6000000, 8'h00));
        pending_q.push_back(build_item(24'd6000001, 8'h30));
        pending_q.push_back(build_item(24'hFFFFFF, 8'hFF));
        pending_q.push_back(build_item(24'd23529, 8'h2F));
        pending_q.push_back(build_item(24'd23530, 8'h30));
        pending_q.push_back(build_item(24'd2941, 8'h27));
        pending_q.push_back(build_item(24'd2942, 8'h28));
        pending_q.push_back(build_item(24'd367, 8'h31));
        pending_q.push_back(build_item(24'd368, 8'h2F));
        pending_q.push_back(build_item(24'd1, 8'h00));
        pending_q.push_back(build_item(24'd45, 8'h80));
        pending_q.push_back(build_item(24'd46, 8'h55));
        pending_q.push_back(build_item(24'd115200, 8'h30));
        pending_q.push_back(build_item(24'd9600, 8'h20));
        pending_q.push_back(build_item(24'd3000000, 8'hAA));
        pending_q.push_back(build_item(24'd0, 8'h00));
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pending_q.push_back(random_item());
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (pending_q.size() > 0 || drv_valid || received_cnt != planned_cnt);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (planned_q.size() > 0) begin
            $display("%0t: missing results, expected %0d more, actual 0", $time,
                     planned_q.size());
            error_cnt++;
        end
        if (error_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/sbb_pkg.sv
rtl/core/sbb_cell.sv
rtl/core/sbb_emit.sv
rtl/core/serial_bridge_baud_init_plan.sv
tb/tb_serial_bridge_baud_init_plan.sv
